// File: rtl/rv32i_dec_pkg.sv
// Package with opcodes, decode codes and result types for the RV32I subset decoder.
package rv32i_dec_pkg;

   localparam int unsigned INSTR_W = 32;
   localparam int unsigned OPCODE_W = 7;
   localparam int unsigned FUNCT3_W = 3;
   localparam int unsigned CLASS_W = 2;
   localparam int unsigned ALU_CTRL_W = 4;

   localparam logic [OPCODE_W-1:0] OP_RTYPE = 7'b0110011;
   localparam logic [OPCODE_W-1:0] OP_ITYPE = 7'b0010011;
   localparam logic [OPCODE_W-1:0] OP_LUI   = 7'b0110111;
   localparam logic [OPCODE_W-1:0] OP_LOAD  = 7'b0000011;
   localparam logic [OPCODE_W-1:0] OP_STORE = 7'b0100011;
   localparam logic [OPCODE_W-1:0] OP_JAL   = 7'b1101111;
   localparam logic [OPCODE_W-1:0] OP_BR    = 7'b1100011;
   localparam logic [OPCODE_W-1:0] OP_NONE  = 7'b0000000;

   localparam logic [FUNCT3_W-1:0] F3_XOR = 3'b100;
   localparam logic [FUNCT3_W-1:0] F3_OR  = 3'b110;
   localparam logic [FUNCT3_W-1:0] F3_SR  = 3'b101;

   localparam logic [CLASS_W-1:0] CLASS_ADD    = 2'd0;
   localparam logic [CLASS_W-1:0] CLASS_BRANCH = 2'd1;
   localparam logic [CLASS_W-1:0] CLASS_FUNCT3 = 2'd2;
   localparam logic [CLASS_W-1:0] CLASS_JUMP   = 2'd3;

   localparam logic [ALU_CTRL_W-1:0] ALU_ADD  = 4'd2;
   localparam logic [ALU_CTRL_W-1:0] ALU_XOR  = 4'd3;
   localparam logic [ALU_CTRL_W-1:0] ALU_OR   = 4'd1;
   localparam logic [ALU_CTRL_W-1:0] ALU_SR   = 4'd4;
   localparam logic [ALU_CTRL_W-1:0] ALU_SUB  = 4'd6;
   localparam logic [ALU_CTRL_W-1:0] ALU_NONE = 4'b1111;

   typedef struct packed {
      logic                  reg_write;
      logic                  alu_src;
      logic                  branch;
      logic                  mem_read;
      logic                  mem_write;
      logic                  mem_to_reg;
      logic [CLASS_W-1:0]    alu_class;
      logic [OPCODE_W-1:0]   opcode_seen;
      logic [ALU_CTRL_W-1:0] alu_control;
   } ctrl_type;

   typedef struct packed {
      ctrl_type                   ctrl;
      logic signed [INSTR_W-1:0] immediate;
   } result_type;

endpackage

// File: rtl/rv32i_dec_ifs.sv
// Valid/ready channel interfaces for instruction beats and decode result beats.
interface rv32i_dec_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] instruction;

   modport source (output valid, output instruction, input ready);
   modport sink (input valid, input instruction, output ready);
endinterface

interface rv32i_dec_rsp_if;
   logic               valid;
   logic               ready;
   logic               reg_write;
   logic               alu_src;
   logic               branch;
   logic               mem_read;
   logic               mem_write;
   logic               mem_to_reg;
   logic [1:0]         alu_class;
   logic [6:0]         opcode_seen;
   logic [3:0]         alu_control;
   logic signed [31:0] immediate;

   modport source (
      output valid, output reg_write, output alu_src, output branch, output mem_read,
      output mem_write, output mem_to_reg, output alu_class, output opcode_seen,
      output alu_control, output immediate, input ready
   );
   modport sink (
      input valid, input reg_write, input alu_src, input branch, input mem_read,
      input mem_write, input mem_to_reg, input alu_class, input opcode_seen,
      input alu_control, input immediate, output ready
   );
endinterface

// File: rtl/rv32i_subset_decoder.sv
// Top level of the RV32I subset decoder: input register, decode logic and result register.
//
// The req_ch channel carries one 32-bit instruction word per beat. The rsp_ch
// channel returns one beat per instruction with the control signals, the ALU
// class, the ALU control code and the sign-extended immediate.
// Both channels use valid/ready; a beat moves on a clock edge where both are high.
// The instruction is captured in an input register, decoded by combinational
// logic and captured again in a result register, from which its result beat is
// offered on rsp_ch and leaves at the first following edge where rsp_ch.ready is high.
// The block takes one instruction every cycle and returns one result every cycle
// while the receiver keeps ready high; the two registers and the ready path set that figure.
// When the receiver stalls, the result register holds its beat and the input
// register holds the next one; req_ch.ready falls only when both are full.
// Results leave in the order in which instructions arrived.
// A synchronous reset empties both registers; there is no other state.
module rv32i_subset_decoder (
   input  logic            clock,
   input  logic            reset,
   rv32i_dec_req_if.sink   req_ch,
   rv32i_dec_rsp_if.source rsp_ch
);
   import rv32i_dec_pkg::*;

   logic               valid_ff;
   logic               valid_in;
   logic [INSTR_W-1:0] instr_ff;
   logic               out_ready;
   logic               load;
   ctrl_type           ctrl;
   logic signed [INSTR_W-1:0] immediate;
   result_type         result;

   assign req_ch.ready = !valid_ff || out_ready;
   assign load = req_ch.valid && req_ch.ready;
   assign valid_in = load || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         instr_ff <= req_ch.instruction;
      end
   end

   rv32i_dec_ctrl u_ctrl (
      .instruction (instr_ff),
      .ctrl        (ctrl)
   );

   rv32i_dec_imm u_imm (
      .instruction (instr_ff),
      .immediate   (immediate)
   );

   assign result.ctrl = ctrl;
   assign result.immediate = immediate;

   rv32i_dec_out u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid_ff),
      .in_ready  (out_ready),
      .in_result (result),
      .rsp_ch    (rsp_ch)
   );

endmodule

// File: rtl/rv32i_dec_ctrl.sv
// Control signal, ALU class and ALU control decode from the opcode and funct3.
module rv32i_dec_ctrl (
   input  logic [rv32i_dec_pkg::INSTR_W-1:0] instruction,
   output rv32i_dec_pkg::ctrl_type           ctrl
);
   import rv32i_dec_pkg::*;

   logic [OPCODE_W-1:0] opcode;
   logic [FUNCT3_W-1:0] funct3;

   assign opcode = instruction[OPCODE_W-1:0];
   assign funct3 = instruction[14:12];

   always_comb begin
      ctrl = '0;
      case (opcode)
         OP_RTYPE: begin
            ctrl.reg_write = 1'b1;
            ctrl.alu_class = CLASS_FUNCT3;
            ctrl.opcode_seen = opcode;
         end
         OP_ITYPE, OP_LUI: begin
            ctrl.reg_write = 1'b1;
            ctrl.alu_src = 1'b1;
            ctrl.alu_class = CLASS_FUNCT3;
            ctrl.opcode_seen = opcode;
         end
         OP_LOAD: begin
            ctrl.reg_write = 1'b1;
            ctrl.alu_src = 1'b1;
            ctrl.mem_read = 1'b1;
            ctrl.mem_to_reg = 1'b1;
            ctrl.alu_class = CLASS_ADD;
            ctrl.opcode_seen = opcode;
         end
         OP_STORE: begin
            ctrl.alu_src = 1'b1;
            ctrl.mem_write = 1'b1;
            ctrl.alu_class = CLASS_ADD;
            ctrl.opcode_seen = opcode;
         end
         OP_JAL: begin
            ctrl.reg_write = 1'b1;
            ctrl.branch = 1'b1;
            ctrl.alu_class = CLASS_JUMP;
            ctrl.opcode_seen = opcode;
         end
         OP_BR: begin
            ctrl.branch = 1'b1;
            ctrl.alu_class = CLASS_BRANCH;
            ctrl.opcode_seen = opcode;
         end
         default: begin
            ctrl.opcode_seen = OP_NONE;
         end
      endcase

      case (ctrl.alu_class)
         CLASS_FUNCT3: begin
            case (funct3)
               F3_XOR:  ctrl.alu_control = ALU_XOR;
               F3_OR:   ctrl.alu_control = ALU_OR;
               F3_SR:   ctrl.alu_control = ALU_SR;
               default: ctrl.alu_control = ALU_ADD;
            endcase
         end
         CLASS_BRANCH: ctrl.alu_control = ALU_SUB;
         CLASS_JUMP:   ctrl.alu_control = ALU_NONE;
         default:      ctrl.alu_control = ALU_ADD;
      endcase
   end

endmodule

// File: rtl/rv32i_dec_imm.sv
// Immediate extraction and sign extension by instruction format.
module rv32i_dec_imm (
   input  logic [rv32i_dec_pkg::INSTR_W-1:0]        instruction,
   output logic signed [rv32i_dec_pkg::INSTR_W-1:0] immediate
);
   import rv32i_dec_pkg::*;

   logic [OPCODE_W-1:0] opcode;
   logic [FUNCT3_W-1:0] funct3;
   logic [INSTR_W-1:0]  w;

   assign w = instruction;
   assign opcode = w[OPCODE_W-1:0];
   assign funct3 = w[14:12];

   always_comb begin
      case (opcode)
         OP_ITYPE: begin
            // Only the or and shift right forms carry an immediate here.
            case (funct3)
               F3_OR:   immediate = {{20{w[31]}}, w[31:20]};
               F3_SR:   immediate = {27'd0, w[24:20]};
               default: immediate = '0;
            endcase
         end
         OP_LUI:   immediate = {w[31:12], 12'd0};
         OP_LOAD:  immediate = {{20{w[31]}}, w[31:20]};
         OP_STORE: immediate = {{20{w[31]}}, w[31:25], w[11:7]};
         OP_BR:    immediate = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
         OP_JAL:   immediate = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
         default:  immediate = '0;
      endcase
   end

endmodule

// File: rtl/rv32i_dec_out.sv
// Result register stage that holds one decoded beat and drives the result channel.
module rv32i_dec_out (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  rv32i_dec_pkg::result_type  in_result,
   rv32i_dec_rsp_if.source            rsp_ch
);
   import rv32i_dec_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;
   logic       load;

   assign in_ready = !valid_ff || rsp_ch.ready;
   assign load = in_valid && in_ready;
   assign valid_in = load || (valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= in_result;
      end
   end

   assign rsp_ch.valid       = valid_ff;
   assign rsp_ch.reg_write   = result_ff.ctrl.reg_write;
   assign rsp_ch.alu_src     = result_ff.ctrl.alu_src;
   assign rsp_ch.branch      = result_ff.ctrl.branch;
   assign rsp_ch.mem_read    = result_ff.ctrl.mem_read;
   assign rsp_ch.mem_write   = result_ff.ctrl.mem_write;
   assign rsp_ch.mem_to_reg  = result_ff.ctrl.mem_to_reg;
   assign rsp_ch.alu_class   = result_ff.ctrl.alu_class;
   assign rsp_ch.opcode_seen = result_ff.ctrl.opcode_seen;
   assign rsp_ch.alu_control = result_ff.ctrl.alu_control;
   assign rsp_ch.immediate   = result_ff.immediate;

endmodule
